// File: design/itsearch_pkg.sv
// ----------------------------------------------------------------------------
// Interval table search package
// Operation codes, item layouts and fixed field widths shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package itsearch_pkg;

    // Widths of the fields at the ports.
    localparam int IO_TIME_W  = 64;
    localparam int OP_W       = 3;
    localparam int INDEX_W    = 8;
    localparam int TOTAL_W    = 9;

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_CLEAR      = 3'd1,
        OP_SEEK_CONT  = 3'd2,
        OP_SEEK_CEIL  = 3'd3,
        OP_SEEK_FLOOR = 3'd4
    } t_op;

    // Status codes of a result item.
    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    // One input item.
    typedef struct packed {
        logic [OP_W-1:0]             operation;
        logic signed [IO_TIME_W-1:0] new_start;
        logic signed [IO_TIME_W-1:0] new_stop;
        logic signed [IO_TIME_W-1:0] query_time;
    } t_req;

    // One result item.
    typedef struct packed {
        logic                        status;
        logic                        found;
        logic [INDEX_W-1:0]          found_index;
        logic signed [IO_TIME_W-1:0] found_start;
        logic signed [IO_TIME_W-1:0] found_stop;
        logic [TOTAL_W-1:0]          entry_total;
    } t_rsp;

endpackage

`default_nettype wire

// File: design/itsearch_if.sv
// ----------------------------------------------------------------------------
// Interval table search channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel.
interface itsearch_req_if
    import itsearch_pkg::*;
;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result channel.
interface itsearch_rsp_if
    import itsearch_pkg::*;
;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/itsearch_ram.sv
// ----------------------------------------------------------------------------
// Interval table search RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module itsearch_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/interval_table_search_top.sv
// Flow: append, clear and unused codes go from idle to the done state, which loads the output
// register; a seek passes through the scan state first and then through the done state.
// Throughput: one item at a time; the next item is taken the cycle after the result is
// loaded, and a seek reads one entry per cycle through the single RAM read port.
// Reset clears the fill count and the control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
// Interval table search top level
// Ordered table of time intervals with append, clear and three linear seeks.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_table_search_top
    import itsearch_pkg::*;
#(
    parameter int MAX_INTERVALS = 256,
    parameter int TIME_BITS     = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    itsearch_req_if.sink      i_req,
    itsearch_rsp_if.source    o_rsp
);

    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int DW = 2 * TIME_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state,     n_state;
    t_op                   r_op,        n_op;
    logic [TIME_BITS-1:0]  r_time,      n_time;
    logic [CW-1:0]         r_count,     n_count;
    logic [CW-1:0]         r_addr,      n_addr;
    logic                  r_pend,      n_pend;
    logic [AW-1:0]         r_pend_idx,  n_pend_idx;
    logic                  r_hit,       n_hit;
    logic [AW-1:0]         r_hit_idx,   n_hit_idx;
    logic [TIME_BITS-1:0]  r_hit_start, n_hit_start;
    logic [TIME_BITS-1:0]  r_hit_stop,  n_hit_stop;
    logic                  r_status,    n_status;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out,       n_out;

    logic                  accept;
    logic                  full;
    logic                  wr_en;
    logic                  rd_en;
    logic [DW-1:0]         wr_data;
    logic [DW-1:0]         rd_data;
    logic [TIME_BITS-1:0]  rd_start;
    logic [TIME_BITS-1:0]  rd_stop;
    logic                  t_lt_start;
    logic                  t_lt_stop;
    logic                  stop_lt_t;
    logic                  more;

    // Interval storage: start in the upper half, stop in the lower half.
    itsearch_ram #(
        .WIDTH  (DW),
        .DEPTH  (MAX_INTERVALS),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CW'(MAX_INTERVALS));
    assign wr_data     = {i_req.data.new_start[TIME_BITS-1:0],
                          i_req.data.new_stop[TIME_BITS-1:0]};
    assign wr_en       = accept && (t_op'(i_req.data.operation) == OP_APPEND) && !full;

    // Compare unit on the entry that came back from the RAM.
    assign rd_start   = rd_data[DW-1:TIME_BITS];
    assign rd_stop    = rd_data[TIME_BITS-1:0];
    assign t_lt_start = $signed(r_time) < $signed(rd_start);
    assign t_lt_stop  = $signed(r_time) < $signed(rd_stop);
    assign stop_lt_t  = $signed(rd_stop) < $signed(r_time);

    // Another entry remains to be read in this scan.
    assign more  = (r_addr < r_count);

    // Sequencer: decode in idle, scan one entry per cycle for a seek, then hand off the result.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_time      = r_time;
        n_count     = r_count;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_hit_start = r_hit_start;
        n_hit_stop  = r_hit_stop;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        rd_en       = 1'b0;

        // The consumer takes the waiting result.
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = t_op'(i_req.data.operation);
                    n_time   = i_req.data.query_time[TIME_BITS-1:0];
                    n_status = ST_DONE;
                    n_hit    = 1'b0;
                    n_addr   = '0;
                    n_pend   = 1'b0;
                    n_state  = S_DONE;
                    case (t_op'(i_req.data.operation))
                        OP_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_SEEK_CONT, OP_SEEK_CEIL, OP_SEEK_FLOOR: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                logic stop_scan;
                stop_scan = 1'b0;
                // Check the entry read in the previous cycle.
                if (r_pend) begin
                    case (r_op)
                        OP_SEEK_CONT: begin
                            if (!t_lt_start && !stop_lt_t) begin
                                n_hit       = 1'b1;
                                n_hit_idx   = r_pend_idx;
                                n_hit_start = rd_start;
                                n_hit_stop  = rd_stop;
                                stop_scan   = 1'b1;
                            end
                        end
                        OP_SEEK_CEIL: begin
                            if (t_lt_stop) begin
                                n_hit       = 1'b1;
                                n_hit_idx   = r_pend_idx;
                                n_hit_start = rd_start;
                                n_hit_stop  = rd_stop;
                                stop_scan   = 1'b1;
                            end
                        end
                        OP_SEEK_FLOOR: begin
                            if (t_lt_start) begin
                                stop_scan = 1'b1;
                            end else begin
                                n_hit       = 1'b1;
                                n_hit_idx   = r_pend_idx;
                                n_hit_start = rd_start;
                                n_hit_stop  = rd_stop;
                            end
                        end
                        default: begin
                            stop_scan = 1'b1;
                        end
                    endcase
                end

                // Issue the next read unless the scan is over.
                if (stop_scan) begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (more) begin
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr[AW-1:0];
                    n_addr     = r_addr + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                // Load the output register once it is free.
                if (!r_out_valid || o_rsp.ready) begin
                    n_out.status      = r_status;
                    n_out.found       = r_hit;
                    n_out.found_index = r_hit ? INDEX_W'(r_hit_idx) : '0;
                    n_out.found_start = r_hit ? IO_TIME_W'(signed'(r_hit_start)) : '0;
                    n_out.found_stop  = r_hit ? IO_TIME_W'(signed'(r_hit_stop)) : '0;
                    n_out.entry_total = TOTAL_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_time      <= n_time;
        r_addr      <= n_addr;
        r_pend_idx  <= n_pend_idx;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_hit_start <= n_hit_start;
        r_hit_stop  <= n_hit_stop;
        r_status    <= n_status;
        r_out       <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

`default_nettype wire

// File: design/itsearch_checker.sv
// ----------------------------------------------------------------------------
// Interval table search checker
// Port-level assertions for the interval table search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module itsearch_checker
    import itsearch_pkg::*;
#(
    parameter int MAX_INTERVALS = 256
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp_data
);

    // A result that waits stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result item dropped while stalled");

    // A result that waits does not change.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_data))
        else $error("result item changed while stalled");

    // The block works on one item at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("item accepted while another is in work");

    // A result without a match carries zero fields.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.found |->
            (i_rsp_data.found_index == '0) && (i_rsp_data.found_start == '0)
            && (i_rsp_data.found_stop == '0))
        else $error("miss result carries nonzero fields");

    // A refused append comes only with a full table and no match.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.status == ST_FULL) |->
            (i_rsp_data.entry_total == TOTAL_W'(MAX_INTERVALS)) && !i_rsp_data.found)
        else $error("full status with a table that is not full");

endmodule

bind interval_table_search_top itsearch_checker #(
    .MAX_INTERVALS (MAX_INTERVALS)
) u_itsearch_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

`default_nettype wire

// File: bench/interval_table_search_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval table search testbench
// Feeds append, clear, seek and unused-code items to the block, with random idling on
// both channels, and checks every result item against a predicted interval table.
// ----------------------------------------------------------------------------

module interval_table_search_top_tb;
    import itsearch_pkg::*;

    localparam int     TABLE_DEPTH = 256;
    localparam int     ITEM_GOAL   = 1550;
    localparam longint T_MAX       = 64'h7fff_ffff_ffff_ffff;
    localparam longint T_MIN       = -T_MAX - 1;

    // Operation codes that the block does not use.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    // Item counts at which the idle-free stretch and the two pressure events fall.
    localparam int CALM_FROM = 700;
    localparam int CALM_TO   = 900;
    localparam int HOLD_AT   = 400;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_AT  = 1100;

    // Predicts the answer to every accepted request and checks the answers
    // that come back, in order.
    class interval_checker;
        logic signed [IO_TIME_W-1:0] starts [TABLE_DEPTH];
        logic signed [IO_TIME_W-1:0] stops  [TABLE_DEPTH];
        int                          fill;
        t_rsp                        pending_answers [$];
        int                          failures;

        function new();
            fill     = 0;
            failures = 0;
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("%0t ns: %s", $time, msg);
            end
        endfunction

        // Apply one request to the predicted table and queue the answer it gives.
        function void take_request(t_req req);
            t_rsp                        answer;
            logic signed [IO_TIME_W-1:0] probe;
            bit                          hit;
            int                          hit_idx;
            answer  = '0;
            probe   = req.query_time;
            hit     = 1'b0;
            hit_idx = 0;
            case (req.operation)
                OP_APPEND: begin
                    if (fill >= TABLE_DEPTH) begin
                        answer.status = ST_FULL;
                    end else begin
                        starts[fill] = req.new_start;
                        stops[fill]  = req.new_stop;
                        fill++;
                    end
                end
                OP_CLEAR: begin
                    fill = 0;
                end
                OP_SEEK_CONT: begin
                    for (int i = 0; i < fill; i++) begin
                        if (probe >= starts[i] && probe <= stops[i]) begin
                            hit     = 1'b1;
                            hit_idx = i;
                            break;
                        end
                    end
                end
                OP_SEEK_CEIL: begin
                    for (int i = 0; i < fill; i++) begin
                        if (probe < stops[i]) begin
                            hit     = 1'b1;
                            hit_idx = i;
                            break;
                        end
                    end
                end
                OP_SEEK_FLOOR: begin
                    // The scan stops at the first start beyond the probe.
                    for (int i = 0; i < fill; i++) begin
                        if (probe < starts[i]) begin
                            break;
                        end
                        hit     = 1'b1;
                        hit_idx = i;
                    end
                end
                default: begin
                end
            endcase
            if (hit) begin
                answer.found       = 1'b1;
                answer.found_index = hit_idx[INDEX_W-1:0];
                answer.found_start = starts[hit_idx];
                answer.found_stop  = stops[hit_idx];
            end
            answer.entry_total = fill[TOTAL_W-1:0];
            pending_answers.push_back(answer);
        endfunction

        function void compare_field(string name, logic [IO_TIME_W-1:0] want,
                                    logic [IO_TIME_W-1:0] got);
            if (want !== got) begin
                note_failure($sformatf("%s: expected %h, got %h", name, want, got));
            end
        endfunction

        // Check one result item against the oldest predicted answer.
        function void check_answer(t_rsp got);
            t_rsp want;
            if (pending_answers.size() == 0) begin
                note_failure("result item arrived with no request waiting");
                return;
            end
            want = pending_answers.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("found", want.found, got.found);
            compare_field("found_index", want.found_index, got.found_index);
            compare_field("found_start", want.found_start, got.found_start);
            compare_field("found_stop", want.found_stop, got.found_stop);
            compare_field("entry_total", want.entry_total, got.entry_total);
        endfunction
    endclass

    logic            clk   = 1'b0;
    logic            rst_n = 1'b0;
    itsearch_req_if  req_ch ();
    itsearch_rsp_if  rsp_ch ();
    interval_checker board = new();
    int              sent_items  = 0;
    bit              calm        = 1'b0;
    int              rx_hold_len = 0;

    always #5 clk = ~clk;

    interval_table_search_top #(
        .MAX_INTERVALS(TABLE_DEPTH),
        .TIME_BITS    (IO_TIME_W)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // A time value: half the time a narrow window around zero so that seeks hit,
    // otherwise fully random bits or an end of the range.
    function automatic longint any_time();
        case ($urandom_range(9))
            0:       return T_MIN;
            1:       return T_MAX;
            2, 3, 4: return {$urandom, $urandom};
            default: return longint'($urandom_range(4000)) - 2000;
        endcase
    endfunction

    // A query time on, next to or midway between the bounds of a stored interval, or any time.
    function automatic longint pick_probe();
        int idx;
        if (board.fill == 0 || $urandom_range(9) == 0) begin
            return any_time();
        end
        idx = $urandom_range(board.fill - 1);
        case ($urandom_range(4))
            0:       return board.starts[idx] - 1;
            1:       return board.starts[idx];
            2:       return board.stops[idx];
            3:       return board.stops[idx] + 1;
            default: return board.starts[idx] + (board.stops[idx] - board.starts[idx]) / 2;
        endcase
    endfunction

    // Offer one request item and hold it until the block accepts it.
    task automatic send_request(input logic [OP_W-1:0] op, input longint t_start,
                                input longint t_stop, input longint t_query);
        t_req req;
        req.operation  = op;
        req.new_start  = t_start;
        req.new_stop   = t_stop;
        req.query_time = t_query;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 10) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= req;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        board.take_request(req);
        sent_items++;
        calm = (sent_items >= CALM_FROM && sent_items < CALM_TO);
    endtask

    // Withdraw the last item offered, then wait until every result is back.
    task automatic wait_for_answers();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (board.pending_answers.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // A table session: usually a fresh table, a run of mostly ordered appends,
    // then seeks placed around the stored bounds.
    task automatic run_table_session();
        int     count;
        longint cursor;
        longint lo;
        if (board.fill == 0 || $urandom_range(3) != 0) begin
            send_request(OP_CLEAR, any_time(), any_time(), any_time());
        end
        count  = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(1, 16);
        cursor = longint'($urandom_range(3000)) - 1500;
        repeat (count) begin
            if ($urandom_range(7) == 0) begin
                send_request(OP_APPEND, any_time(), any_time(), any_time());
            end else begin
                // Now and then the stop lands before the start.
                lo = cursor + $urandom_range(20);
                send_request(OP_APPEND, lo,
                             lo + $urandom_range(30) - (($urandom_range(7) == 0) ? 5 : 0),
                             any_time());
                cursor = lo + $urandom_range(1, 25);
            end
        end
        repeat ($urandom_range(4, 12)) begin
            send_request(OP_W'($urandom_range(OP_SEEK_CONT, OP_SEEK_FLOOR)), any_time(),
                         any_time(), pick_probe());
        end
    endtask

    // Fill the table to the top, push appends against the full table, seek
    // three times into the full table and clear again.
    task automatic run_full_table();
        longint cursor;
        cursor = longint'($urandom_range(1000)) - 500;
        if ($urandom_range(1) == 0) begin
            send_request(OP_CLEAR, any_time(), any_time(), any_time());
        end
        while (board.fill < TABLE_DEPTH) begin
            send_request(OP_APPEND, cursor, cursor + $urandom_range(40), any_time());
            cursor = cursor + $urandom_range(1, 30);
        end
        repeat ($urandom_range(1, 3)) begin
            send_request(OP_APPEND, any_time(), any_time(), any_time());
        end
        repeat (3) begin
            send_request(OP_W'($urandom_range(OP_SEEK_CONT, OP_SEEK_FLOOR)), any_time(),
                         any_time(), pick_probe());
        end
        send_request(OP_CLEAR, any_time(), any_time(), any_time());
    endtask

    // Random codes, spare ones included, with random fields.
    task automatic run_noise();
        repeat ($urandom_range(4, 10)) begin
            send_request(OP_W'($urandom_range(OP_SPARE_LAST)), any_time(), any_time(),
                         ($urandom_range(1) == 0) ? pick_probe() : any_time());
        end
    endtask

    // Result side: random stalls, the long hold-off, and the check of each item.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                board.check_answer(rsp_ch.data);
            end
            @(negedge clk);
            if (rx_hold_len > 0) begin
                rsp_ch.ready <= 1'b0;
                rx_hold_len--;
            end else begin
                rsp_ch.ready <= calm || ($urandom_range(99) >= 10);
            end
        end
    end

    // Request side: reset, directed items, random sessions, then the drain.
    initial begin
        bit hold_done;
        bit drain_done;
        int pick;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Seeks on an empty table find nothing.
        send_request(OP_SEEK_CONT, 0, 0, 0);
        send_request(OP_SEEK_CEIL, 0, 0, T_MAX);
        send_request(OP_SEEK_FLOOR, 0, 0, T_MIN);

        // Spare operation codes leave the table alone.
        for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
            send_request(OP_W'(code), T_MAX, T_MIN, T_MAX);
        end

        // Points at both ends of the range, a negative interval, a point at
        // zero and an interval whose stop lies before its start.
        send_request(OP_APPEND, T_MIN, T_MIN, 0);
        send_request(OP_APPEND, -100, -50, 0);
        send_request(OP_APPEND, 0, 0, 0);
        send_request(OP_APPEND, 10, -10, 0);
        send_request(OP_APPEND, T_MAX, T_MAX, 0);

        // Seeks at the extremes, inside an interval and in a gap.
        send_request(OP_SEEK_CONT, 0, 0, T_MIN);
        send_request(OP_SEEK_CONT, 0, 0, -75);
        send_request(OP_SEEK_CONT, 0, 0, T_MAX);
        send_request(OP_SEEK_CONT, 0, 0, 5);
        send_request(OP_SEEK_CEIL, 0, 0, T_MIN);
        send_request(OP_SEEK_CEIL, 0, 0, T_MAX);
        send_request(OP_SEEK_FLOOR, 0, 0, T_MIN);
        send_request(OP_SEEK_FLOOR, 0, 0, T_MAX);
        send_request(OP_SEEK_FLOOR, 0, 0, 5);

        // A cleared table finds nothing again.
        send_request(OP_CLEAR, 0, 0, 0);
        send_request(OP_SEEK_FLOOR, 0, 0, 0);

        // The full-table case comes once for sure, then at random.
        run_full_table();
        while (sent_items < ITEM_GOAL) begin
            if (!hold_done && sent_items >= HOLD_AT) begin
                rx_hold_len = HOLD_LEN;
                hold_done   = 1'b1;
            end
            if (!drain_done && sent_items >= DRAIN_AT) begin
                wait_for_answers();
                drain_done = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 3) begin
                run_full_table();
            end else if (pick < 78) begin
                run_table_session();
            end else begin
                run_noise();
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        wait_for_answers();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (board.pending_answers.size() != 0) begin
            board.note_failure($sformatf("%0d result items never arrived",
                                         board.pending_answers.size()));
        end
        if (board.failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(30_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
design/itsearch_pkg.sv
design/itsearch_if.sv
design/itsearch_ram.sv
design/interval_table_search_top.sv
design/itsearch_checker.sv
bench/interval_table_search_top_tb.sv
